FILE: design/wlac_pkg.sv
// shared types and constants of the windowed lag autocorrelation block
`default_nettype none

package wlac_pkg;

    // fixed field widths
    localparam int VOLUME_FIELD_BITS = 24;
    localparam int RATIO_BITS        = 32;
    localparam int LAG_BITS          = 8;
    localparam int WINDOW_BITS       = 10;
    localparam int CFG_DATA_BITS     = 10;
    localparam int FRAC_BITS         = 24;
    // window_bars + 1 never exceeds 1024
    localparam int N_BITS            = 11;

    localparam logic [LAG_BITS-1:0]    LAG_RESET    = 8'd1;
    localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 10'd200;

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_LAG    = 1'b0,
        REG_WINDOW = 1'b1
    } cfg_reg_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SUM,
        ST_PINIT,
        ST_MX,
        ST_MY,
        ST_CB,
        ST_AB0,
        ST_AB1,
        ST_AA0,
        ST_AA1,
        ST_FLUSH,
        ST_DCHK,
        ST_DIV,
        ST_RESULT
    } state_t;

    // where a registered partial product goes
    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_NUM,
        ACC_DEN
    } acc_t;

endpackage

`default_nettype wire

FILE: design/windowed_lag_autocorrelation.sv
// windowed lag autocorrelation of bar volumes, top level
// an item that finds too few samples stored gives no result; else the time per item
//   grows with n and pairs, n = min(count, window_bars+1), pairs = n - lag, and is
//   set by the one shared multiplier (two centrings and four partial products per
//   pair) and the bit-serial divider
// one item at a time: s_tready is high only while the sequencer is idle
// aresetn (synchronous, active low) clears pointer, count, registers and control
// the sample ring has no reset; only written entries are ever read
`default_nettype none

module windowed_lag_autocorrelation
    import wlac_pkg::*;
#(
    parameter int RING_DEPTH  = 1024,
    parameter int VOLUME_BITS = 24
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // input items
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [VOLUME_FIELD_BITS-1:0]  s_tdata,   // [23:0] volume
    // result items
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [RATIO_BITS-1:0]              m_tdata,   // [31:0] ratio
    output logic [1:0]                         m_tuser,   // [0] saturated, [1] zero_denominator
    // configuration writes
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [0:0]                    cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]      cfg_data
);

    localparam int AW    = $clog2(RING_DEPTH);
    localparam int CNTW  = $clog2(RING_DEPTH + 1);
    localparam int CMPW  = (CNTW > N_BITS) ? CNTW : N_BITS;
    // magnitude of a sum or a centred sample
    localparam int MW    = VOLUME_BITS + 10;
    localparam int HALF  = (MW + 1) / 2;
    localparam int MB    = (HALF > N_BITS) ? HALF : N_BITS;
    localparam int PRW   = MW + MB;
    localparam int DENW  = 2 * MW + 10;
    localparam int NUMW  = DENW + 1;
    localparam int DIVN  = DENW + FRAC_BITS;
    localparam int DCW   = $clog2(DIVN);

    // sample ring, registered reads at two ages
    logic [VOLUME_BITS-1:0] ring_mem [RING_DEPTH];
    logic [VOLUME_BITS-1:0] rd_a_reg, rd_b_reg;

    state_t state_reg, state_next;

    logic [AW-1:0]          wp_reg, wp_next;
    logic [AW-1:0]          newest_reg, newest_next;
    logic [CNTW-1:0]        count_reg, count_next;
    logic [LAG_BITS-1:0]    lag_reg;
    logic [WINDOW_BITS-1:0] win_reg;
    logic [N_BITS-1:0]      n_reg, n_next;
    logic [N_BITS-1:0]      j_reg, j_next;
    logic [MW-1:0]          sum_reg, sum_next;
    logic [PRW-1:0]         prod_reg, prod_next;
    acc_t                   acc_reg, acc_next;
    logic                   acc_hi_reg, acc_hi_next;
    logic [MW-1:0]          ma_reg, ma_next, mb_reg, mb_next;
    logic                   sa_reg, sa_next, sb_reg, sb_next;
    logic [NUMW-1:0]        num_reg, num_next;
    logic [DENW-1:0]        den_reg, den_next;
    logic [DIVN-1:0]        dv_reg, dv_next;
    logic [DENW-1:0]        r_reg, r_next;
    logic [32:0]            q_reg, q_next;
    logic                   ovf_reg, ovf_next;
    logic                   neg_reg, neg_next;
    logic                   zd_reg, zd_next;
    logic [DCW-1:0]         cnt_reg, cnt_next;
    logic                   m_valid_reg, m_valid_next;
    logic [RATIO_BITS-1:0]  m_data_reg, m_data_next;
    logic [1:0]             m_user_reg, m_user_next;

    // shared multiplier operands
    logic [MW-1:0] mul_a;
    logic [MB-1:0] mul_b;

    logic                   s_acc;
    logic [VOLUME_BITS-1:0] s_sample;
    logic [N_BITS-1:0]      age_b;
    logic [AW-1:0]          addr_a, addr_b;
    logic [N_BITS-1:0]      win1, pairs;
    logic                   too_few;
    logic [MW:0]            diff, diff_neg;
    logic [MW-1:0]          cmag;
    logic [NUMW-1:0]        acc_ext;
    logic [NUMW-1:0]        num_mag;
    logic [DENW:0]          r_try;
    logic                   r_ge;
    logic [32:0]            limit, q_sat, q_neg;
    logic                   sat;

    // address of the sample that is age steps older than the newest
    function automatic logic [AW-1:0] age_addr(input logic [AW-1:0] newest,
                                               input logic [N_BITS-1:0] age);
        logic [AW:0] a;
        logic [AW:0] nw;
        a  = (AW+1)'(age);
        nw = {1'b0, newest};
        if (nw >= a) begin
            return AW'(nw - a);
        end else begin
            return AW'(nw + (AW+1)'(RING_DEPTH) - a);
        end
    endfunction

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign s_sample  = VOLUME_BITS'(s_tdata);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;

    assign age_b  = j_reg + N_BITS'(lag_reg);
    assign addr_a = age_addr(newest_reg, j_reg);
    assign addr_b = age_addr(newest_reg, age_b);

    assign win1    = N_BITS'(win_reg) + N_BITS'(1);
    assign too_few = CMPW'(count_reg) <= CMPW'(lag_reg);
    assign pairs   = (n_reg > N_BITS'(lag_reg)) ? n_reg - N_BITS'(lag_reg) : '0;

    // centring: n*v - S from the last product
    assign diff     = {1'b0, prod_reg[MW-1:0]} - {1'b0, sum_reg};
    assign diff_neg = -diff;
    assign cmag     = diff[MW] ? diff_neg[MW-1:0] : diff[MW-1:0];

    assign acc_ext = acc_hi_reg ? (NUMW'(prod_reg) << HALF) : NUMW'(prod_reg);
    assign num_mag = num_reg[NUMW-1] ? -num_reg : num_reg;

    // restoring divider step, one quotient bit a cycle
    assign r_try = {r_reg, dv_reg[DIVN-1]};
    assign r_ge  = r_try >= {1'b0, den_reg};

    assign limit = neg_reg ? 33'h080000000 : 33'h07FFFFFFF;
    assign sat   = ovf_reg || (q_reg > limit);
    assign q_sat = sat ? limit : q_reg;
    assign q_neg = -q_sat;

    // ring write and reads
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            ring_mem[wp_reg] <= s_sample;
        end
        rd_a_reg <= ring_mem[addr_a];
        rd_b_reg <= ring_mem[addr_b];
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lag_reg <= LAG_RESET;
            win_reg <= WINDOW_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_LAG:    lag_reg <= cfg_data[LAG_BITS-1:0];
                REG_WINDOW: win_reg <= cfg_data[WINDOW_BITS-1:0];
                default:    lag_reg <= lag_reg;
            endcase
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            wp_reg      <= '0;
            newest_reg  <= '0;
            count_reg   <= '0;
            acc_reg     <= ACC_NONE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wp_reg      <= wp_next;
            newest_reg  <= newest_next;
            count_reg   <= count_next;
            acc_reg     <= acc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        n_reg      <= n_next;
        j_reg      <= j_next;
        sum_reg    <= sum_next;
        prod_reg   <= prod_next;
        acc_hi_reg <= acc_hi_next;
        ma_reg     <= ma_next;
        mb_reg     <= mb_next;
        sa_reg     <= sa_next;
        sb_reg     <= sb_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        dv_reg     <= dv_next;
        r_reg      <= r_next;
        q_reg      <= q_next;
        ovf_reg    <= ovf_next;
        neg_reg    <= neg_next;
        zd_reg     <= zd_next;
        cnt_reg    <= cnt_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_acc) state_next = ST_CHECK;
            ST_CHECK:  state_next = too_few ? ST_IDLE : ST_SUM;
            ST_SUM:    if (j_reg == n_reg) state_next = ST_PINIT;
            ST_PINIT:  state_next = (pairs == '0) ? ST_RESULT : ST_MX;
            ST_MX:     state_next = ST_MY;
            ST_MY:     state_next = ST_CB;
            ST_CB:     state_next = ST_AB0;
            ST_AB0:    state_next = ST_AB1;
            ST_AB1:    state_next = ST_AA0;
            ST_AA0:    state_next = ST_AA1;
            ST_AA1:    state_next = (j_reg == pairs) ? ST_FLUSH : ST_MX;
            ST_FLUSH:  state_next = ST_DCHK;
            ST_DCHK:   state_next = (den_reg == '0) ? ST_RESULT : ST_DIV;
            ST_DIV:    if (cnt_reg == DCW'(DIVN - 1)) state_next = ST_RESULT;
            ST_RESULT: if (!m_valid_reg || m_tready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        wp_next      = wp_reg;
        newest_next  = newest_reg;
        count_next   = count_reg;
        n_next       = n_reg;
        j_next       = j_reg;
        sum_next     = sum_reg;
        acc_next     = ACC_NONE;
        acc_hi_next  = 1'b0;
        ma_next      = ma_reg;
        mb_next      = mb_reg;
        sa_next      = sa_reg;
        sb_next      = sb_reg;
        num_next     = num_reg;
        den_next     = den_reg;
        dv_next      = dv_reg;
        r_next       = r_reg;
        q_next       = q_reg;
        ovf_next     = ovf_reg;
        neg_next     = neg_reg;
        zd_next      = zd_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        mul_a        = ma_reg;
        mul_b        = MB'(mb_reg[HALF-1:0]);

        // pending partial product lands in its accumulator
        case (acc_reg)
            ACC_NUM: num_next = num_reg + ((sa_reg ^ sb_reg) ? -acc_ext : acc_ext);
            ACC_DEN: den_next = den_reg + DENW'(acc_ext);
            default: num_next = num_reg;
        endcase

        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    newest_next = wp_reg;
                    wp_next     = (wp_reg == AW'(RING_DEPTH - 1)) ? '0 : wp_reg + AW'(1);
                    if (count_reg != CNTW'(RING_DEPTH)) begin
                        count_next = count_reg + CNTW'(1);
                    end
                end
            end
            ST_CHECK: begin
                n_next   = (CMPW'(count_reg) < CMPW'(win1)) ? N_BITS'(count_reg) : win1;
                j_next   = '0;
                sum_next = '0;
            end
            ST_SUM: begin
                // data read at age j-1 arrives now
                if (j_reg != '0) begin
                    sum_next = sum_reg + MW'(rd_a_reg);
                end
                j_next = (j_reg == n_reg) ? '0 : j_reg + N_BITS'(1);
            end
            ST_PINIT: begin
                num_next = '0;
                den_next = '0;
                zd_next  = (pairs == '0);
            end
            ST_MX: begin
                mul_a = MW'(rd_a_reg);
                mul_b = MB'(n_reg);
            end
            ST_MY: begin
                mul_a   = MW'(rd_b_reg);
                mul_b   = MB'(n_reg);
                ma_next = cmag;
                sa_next = diff[MW];
            end
            ST_CB: begin
                mb_next = cmag;
                sb_next = diff[MW];
            end
            ST_AB0: begin
                mul_b    = MB'(mb_reg[HALF-1:0]);
                acc_next = ACC_NUM;
                j_next   = j_reg + N_BITS'(1);
            end
            ST_AB1: begin
                mul_b       = MB'(mb_reg[MW-1:HALF]);
                acc_next    = ACC_NUM;
                acc_hi_next = 1'b1;
            end
            ST_AA0: begin
                mul_b    = MB'(ma_reg[HALF-1:0]);
                acc_next = ACC_DEN;
            end
            ST_AA1: begin
                mul_b       = MB'(ma_reg[MW-1:HALF]);
                acc_next    = ACC_DEN;
                acc_hi_next = 1'b1;
            end
            ST_DCHK: begin
                zd_next  = (den_reg == '0);
                neg_next = num_reg[NUMW-1];
                dv_next  = {DENW'(num_mag), FRAC_BITS'(0)};
                r_next   = '0;
                q_next   = '0;
                ovf_next = 1'b0;
                cnt_next = '0;
            end
            ST_DIV: begin
                r_next   = r_ge ? DENW'(r_try - {1'b0, den_reg}) : DENW'(r_try);
                dv_next  = dv_reg << 1;
                q_next   = {q_reg[31:0], r_ge};
                ovf_next = ovf_reg || q_reg[32];
                cnt_next = cnt_reg + DCW'(1);
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    if (zd_reg) begin
                        m_data_next = '0;
                        m_user_next = 2'b10;
                    end else begin
                        m_data_next = neg_reg ? q_neg[31:0] : q_sat[31:0];
                        m_user_next = {1'b0, sat};
                    end
                end
            end
            default: begin
                j_next = j_reg;
            end
        endcase

        prod_next = PRW'(mul_a) * PRW'(mul_b);
    end

    // a zero denominator always gives a zero, unclipped ratio
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> (m_tdata == '0 && !m_tuser[0]))
        else $error("zero denominator result carries a nonzero ratio");

    // a clipped ratio sits at one end of the range
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |->
            (m_tdata == 32'h7FFFFFFF || m_tdata == 32'h80000000))
        else $error("saturated ratio is not at a range limit");

    // an accepted item keeps the block busy in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while previous item still in work");

    // a new result is loaded only when the output slot is free or drains
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// self-checking testbench of the windowed lag autocorrelation block
`default_nettype none

module testbench
    import wlac_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  DEPTH        = 1024;
    localparam int  SETTLE       = 40;       // cycles after the last result
    localparam longint CYCLE_CAP = 4000000;  // generous run limit

    // one expected result item
    typedef struct {
        logic [RATIO_BITS-1:0] ratio;
        bit                    saturated;
        bit                    zero_den;
    } autocorr_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [VOLUME_FIELD_BITS-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [RATIO_BITS-1:0] m_tdata;
    logic [1:0] m_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [0:0] cfg_index = REG_LAG;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    // predictor state: ring, pointer, count and the two registers
    logic [VOLUME_FIELD_BITS-1:0] volume_ring [DEPTH];
    logic [9:0]  ring_wptr = '0;
    int          stored_count = 0;
    int          cur_lag = int'(LAG_RESET);
    int          cur_window = int'(WINDOW_RESET);

    autocorr_t   pending_ratios [$];
    int          error_count = 0;
    longint      cycle_count = 0;
    bit          no_idle = 1'b0;     // stretches with no gaps on either side
    int          hold_request = 0;   // long receiver hold-off asked by a test
    int          hold_left = 0;
    int          rx_gap = 0;

    windowed_lag_autocorrelation dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),     // [23:0] volume
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),     // [31:0] ratio
        .m_tuser   (m_tuser),     // [0] saturated, [1] zero_denominator
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // hard stop if the block hangs
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        if (no_idle) return 0;
        if ($urandom_range(0, 99) < 85) return $urandom_range(0, 3);
        return $urandom_range(10, 60);
    endfunction

    // random volume over the full field range
    function automatic logic [VOLUME_FIELD_BITS-1:0] rand_volume();
        return VOLUME_FIELD_BITS'($urandom_range(0, 24'hFFFFFF));
    endfunction

    // stored volume by age, age 0 is the newest
    function automatic logic [VOLUME_FIELD_BITS-1:0] volume_at_age(int age);
        logic [9:0] idx;
        idx = ring_wptr - 10'd1 - age[9:0];
        return volume_ring[idx];
    endfunction

    // stores one volume and queues the ratio it produces, if any
    function automatic void predict_ratio(logic [VOLUME_FIELD_BITS-1:0] vol);
        int n, pairs;
        longint win_sum, ca, cb;
        logic signed [127:0] num, den, wa, wb;
        logic [127:0] mag, quot, limit;
        bit neg;
        autocorr_t r;
        volume_ring[ring_wptr] = vol;
        ring_wptr = ring_wptr + 10'd1;
        if (stored_count < DEPTH) stored_count++;
        if (stored_count <= cur_lag) return;
        n = cur_window + 1;
        if (n > stored_count) n = stored_count;
        win_sum = 0;
        for (int j = 0; j < n; j++) win_sum += longint'(volume_at_age(j));
        pairs = (n > cur_lag) ? n - cur_lag : 0;
        num = '0;
        den = '0;
        for (int j = 0; j < pairs; j++) begin
            // centring by n*v - sum keeps everything integer
            ca = longint'(n) * longint'(volume_at_age(j)) - win_sum;
            cb = longint'(n) * longint'(volume_at_age(j + cur_lag)) - win_sum;
            wa = 128'(ca);
            wb = 128'(cb);
            num = num + wa * wb;
            den = den + wa * wa;
        end
        r.ratio = '0;
        r.saturated = 1'b0;
        r.zero_den = 1'b0;
        if (den == '0) begin
            r.zero_den = 1'b1;
        end else begin
            neg = num[127];
            mag = neg ? -num : num;
            mag = mag << FRAC_BITS;
            quot = mag / 128'(den);
            limit = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
            if (quot > limit) begin
                quot = limit;
                r.saturated = 1'b1;
            end
            r.ratio = neg ? -quot[31:0] : quot[31:0];
        end
        pending_ratios.push_back(r);
    endfunction

    // result side: random stalls, a long hold-off on request, and the check
    always @(posedge aclk) begin
        autocorr_t exp_r;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_ratios.size() == 0) begin
                    $error("result item with none expected: ratio %h", m_tdata);
                    error_count++;
                end else begin
                    exp_r = pending_ratios.pop_front();
                    if (m_tdata !== exp_r.ratio) begin
                        $error("ratio: expected %h actual %h", exp_r.ratio, m_tdata);
                        error_count++;
                    end
                    if (m_tuser[0] !== exp_r.saturated) begin
                        $error("saturated: expected %0d actual %0d",
                               exp_r.saturated, m_tuser[0]);
                        error_count++;
                    end
                    if (m_tuser[1] !== exp_r.zero_den) begin
                        $error("zero_denominator: expected %0d actual %0d",
                               exp_r.zero_den, m_tuser[1]);
                        error_count++;
                    end
                end
            end
            if (hold_request != 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (rx_gap != 0) begin
                rx_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) rx_gap = pick_gap();
            end
        end
    end

    // offers one volume item and predicts on acceptance
    task automatic send_volume(input logic [VOLUME_FIELD_BITS-1:0] vol);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= vol;
        do @(posedge aclk); while (!s_tready);
        predict_ratio(vol);
    endtask

    // waits until the block is idle: nothing expected, then the short no-result pass
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_ratios.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_BITS-1:0];
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_LAG) cur_lag = value & 8'hFF;
        else cur_window = value & 10'h3FF;
        @(posedge aclk);
    endtask

    task automatic set_lag_window(input int lag_v, input int win_v);
        drain_results();
        write_reg(REG_LAG, lag_v);
        write_reg(REG_WINDOW, win_v);
    endtask

    // reset settings, volume extremes, a flat run giving a zero denominator
    task automatic test_reset_settings();
        send_volume(24'hFFFFFF);   // too few samples, no result
        send_volume(24'h000000);
        send_volume(24'hFFFFFF);
        send_volume(24'h000000);
        send_volume(24'd12345);
        drain_results();
        write_reg(REG_WINDOW, 2);
        repeat (4) send_volume(24'd777);   // flat window
    endtask

    // narrowest window that has pairs, window without pairs, widest lag
    task automatic test_window_extremes();
        set_lag_window(1, 1);
        send_volume(24'd5);
        send_volume(24'hFFFFFF);
        send_volume(24'hFFFFFF);
        set_lag_window(5, 1);      // window+1 <= lag: no pairs
        send_volume(24'd100);
        send_volume(24'd3);
        set_lag_window(255, 1023);
        send_volume(24'd42);
        send_volume(24'hABCDEF);
    endtask

    // small late deviations against large early ones push the ratio out of range
    task automatic test_saturation();
        set_lag_window(2, 3);
        send_volume(24'd499);
        send_volume(24'd1500);
        send_volume(24'd1000);
        send_volume(24'd1001);     // positive clip
        send_volume(24'd1499);
        send_volume(24'd500);
        send_volume(24'd1000);
        send_volume(24'd1001);     // negative clip
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        set_lag_window(1, 8);
        hold_request = 3000;
        repeat (6) send_volume(rand_volume());
    endtask

    // random phases with random settings and volume shapes
    task automatic test_random();
        int shape, base;
        for (int phase = 0; phase < 9; phase++) begin
            if (phase == 4) set_lag_window(1, 200);
            else if (phase == 7) set_lag_window($urandom_range(1, 255), $urandom_range(1, 40));
            else set_lag_window($urandom_range(1, 8), $urandom_range(1, 40));
            no_idle = ($urandom_range(0, 3) == 0);
            shape = $urandom_range(0, 2);
            base = $urandom_range(0, 24'hFFFF00);
            for (int k = 0; k < 25; k++) begin
                case (shape)
                    0: send_volume(rand_volume());
                    1: send_volume(VOLUME_FIELD_BITS'(base + $urandom_range(0, 3))); // near-flat
                    default: send_volume(($urandom_range(0, 1) != 0) ? 24'hFFFFFF
                                         : VOLUME_FIELD_BITS'($urandom_range(0, 15)));
                endcase
            end
        end
        no_idle = 1'b0;
    endtask

    // widest windows over everything stored so far
    task automatic test_wide_window();
        set_lag_window(1, 1023);
        repeat (3) send_volume(rand_volume());
        set_lag_window(255, 1023);
        repeat (2) send_volume(rand_volume());
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);
        test_reset_settings();
        test_window_extremes();
        test_saturation();
        test_backpressure();
        test_random();
        test_wide_window();
        drain_results();
        if (error_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
design/wlac_pkg.sv
design/windowed_lag_autocorrelation.sv
tb/sv/testbench.sv
